[src/bgts_pkg.sv]
// shared constants and types for the binary grid threshold smoother
`timescale 1ns / 1ps
package bgts_pkg;

	localparam int ROW_W      = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int WIDTH_W    = 7;
	localparam int THR_W      = 4;
	localparam int CNT_W      = 4;
	localparam int COL_SUM_W  = 2;
	localparam int COL_IDX_W  = $clog2(ROW_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int FIFO_DEPTH = 2;

	localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET      = 7'd25;
	localparam logic [THR_W-1:0]   WALL_THRESHOLD_RESET = 4'd5;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESHOLD = 2'd1;

	// control shared by every column cell
	typedef struct packed {
		logic               shift;
		logic               clear;
		logic               smooth;
		logic [WIDTH_W-1:0] width;
		logic [THR_W-1:0]   thr;
	} cell_ctrl_t;

	// results caused by one input row
	typedef struct packed {
		logic [ROW_W-1:0] res_row;
		logic             res_ok;
		logic [ROW_W-1:0] flush_row;
		logic             flush_ok;
	} out_entry_t;

endpackage

[src/bgts_if.sv]
// channel interfaces: input rows, result rows and configuration writes
`timescale 1ns / 1ps
interface bgts_row_if;
	import bgts_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] in_row;
	logic             last_row;
	modport source (output valid, output in_row, output last_row, input ready);
	modport sink (input valid, input in_row, input last_row, output ready);
endinterface

interface bgts_res_if;
	import bgts_pkg::*;
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] out_row;
	logic             out_last;
	modport source (output valid, output out_row, output out_last, input ready);
	modport sink (input valid, input out_row, input out_last, output ready);
endinterface

interface bgts_cfg_if;
	import bgts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

[src/binary_grid_threshold_smoother_unit.sv]
// top level: config registers, row counter, column cell chain and result queue
`timescale 1ns / 1ps
// One smoothing pass over a binary wall/floor grid streamed one row per request, with
// the bottom row marked by last_row. Each column is a small cell holding that column's
// two previous rows; it shares its vertical wall count with its neighbors so all 3x3
// counts form in parallel. A row is taken every cycle: the first row of a
// frame yields nothing, later rows yield the row above (top row unchanged, others
// smoothed), and the last row also yields itself with out_last set. Results go
// through a two-entry queue; the input stalls only while that queue is full.
// Configuration writes (row_width, wall_threshold) are always ready and
// belong between frames.
module binary_grid_threshold_smoother_unit import bgts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bgts_cfg_if.sink   cfg,
	bgts_row_if.sink   row_in,
	bgts_res_if.source row_out
);

	logic [WIDTH_W-1:0]   row_width_q;
	logic [THR_W-1:0]     wall_threshold_q;
	logic [1:0]           rows_seen_q;
	logic                 accept;
	logic                 full;
	logic                 push;
	cell_ctrl_t           ctrl;
	out_entry_t           entry;
	logic [COL_SUM_W-1:0] col_sum [ROW_W];
	logic [ROW_W-1:0]     res_bits;
	logic [ROW_W-1:0]     flush_bits;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q      <= ROW_WIDTH_RESET;
			wall_threshold_q <= WALL_THRESHOLD_RESET;
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_ROW_WIDTH: begin
					row_width_q <= cfg.data[WIDTH_W-1:0];
				end
				REG_WALL_THRESHOLD: begin
					wall_threshold_q <= cfg.data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign row_in.ready = !full;
	assign accept       = row_in.valid && row_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_seen_q <= 2'd0;
		end else if (accept) begin
			if (row_in.last_row) begin
				rows_seen_q <= 2'd0;
			end else if (rows_seen_q != 2'd2) begin
				rows_seen_q <= rows_seen_q + 2'd1;
			end
		end
	end

	always_comb begin
		ctrl.shift  = accept && !row_in.last_row;
		ctrl.clear  = accept && row_in.last_row;
		ctrl.smooth = (rows_seen_q == 2'd2);
		ctrl.width  = (row_width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : row_width_q;
		ctrl.thr    = wall_threshold_q;
	end

	for (genvar i = 0; i < ROW_W; i++) begin : g_col
		logic [COL_SUM_W-1:0] left_sum;
		logic [COL_SUM_W-1:0] right_sum;
		if (i == 0) begin : g_left_edge
			assign left_sum = '0;
		end else begin : g_left
			assign left_sum = col_sum[i-1];
		end
		if (i == ROW_W - 1) begin : g_right_edge
			assign right_sum = '0;
		end else begin : g_right
			assign right_sum = col_sum[i+1];
		end
		bgts_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.col_idx   (COL_IDX_W'(i)),
			.in_bit    (row_in.in_row[i]),
			.left_sum  (left_sum),
			.right_sum (right_sum),
			.col_sum   (col_sum[i]),
			.res_bit   (res_bits[i]),
			.flush_bit (flush_bits[i])
		);
	end

	// first row of a frame only loads the cells unless it is also the last
	assign push = accept && ((rows_seen_q != 2'd0) || row_in.last_row);

	always_comb begin
		entry.res_row   = res_bits;
		entry.res_ok    = (rows_seen_q != 2'd0);
		entry.flush_row = flush_bits;
		entry.flush_ok  = row_in.last_row;
	end

	bgts_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.full       (full),
		.res_out    (row_out)
	);

`ifndef NO_ASSERTIONS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_in.last_row |=> rows_seen_q == 2'd0)
		else $error("row count not cleared after last row");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rows_seen_q != 2'd3)
		else $error("row count beyond two");
	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !row_in.last_row && rows_seen_q == 2'd0 |=> rows_seen_q == 2'd1)
		else $error("first row not counted");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result queue written while full");
`endif

endmodule

[src/bgts_cell.sv]
// one grid column: holds upper and middle bits and forms the smoothed bit
`timescale 1ns / 1ps
module bgts_cell import bgts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [COL_IDX_W-1:0] col_idx,
	input  logic                 in_bit,
	input  logic [COL_SUM_W-1:0] left_sum,
	input  logic [COL_SUM_W-1:0] right_sum,
	output logic [COL_SUM_W-1:0] col_sum,
	output logic                 res_bit,
	output logic                 flush_bit
);

	logic               up_q;
	logic               mid_q;
	logic [CNT_W-1:0]   cnt;
	logic [WIDTH_W-1:0] idx_ext;
	logic               in_width;
	logic               interior;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q  <= 1'b0;
			mid_q <= 1'b0;
		end else if (ctrl.clear) begin
			up_q  <= 1'b0;
			mid_q <= 1'b0;
		end else if (ctrl.shift) begin
			up_q  <= mid_q;
			mid_q <= in_bit;
		end
	end

	// vertical count handed to both neighbors
	assign col_sum = {1'b0, up_q} + {1'b0, mid_q} + {1'b0, in_bit};

	assign idx_ext  = {{(WIDTH_W-COL_IDX_W){1'b0}}, col_idx};
	assign in_width = idx_ext < ctrl.width;
	assign interior = (col_idx != '0) && ((idx_ext + 7'd1) < ctrl.width);
	assign cnt      = CNT_W'(left_sum) + CNT_W'(col_sum) + CNT_W'(right_sum);

	always_comb begin
		res_bit = mid_q & in_width;
		if (ctrl.smooth && interior) begin
			res_bit = (cnt >= ctrl.thr);
		end
	end

	assign flush_bit = in_bit & in_width;

endmodule

[src/bgts_out_fifo.sv]
// two-entry result queue, each entry sends one or two result rows
`timescale 1ns / 1ps
module bgts_out_fifo import bgts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  out_entry_t   push_entry,
	output logic         full,
	bgts_res_if.source   res_out
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_Q_W = $clog2(FIFO_DEPTH + 1);

	out_entry_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_Q_W-1:0] count_q;
	logic               phase_q;
	out_entry_t         head;
	logic               show_res;
	logic               take;
	logic               pop;

	assign head     = mem_q[rd_ptr_q];
	assign show_res = head.res_ok && !phase_q;
	assign full     = (count_q == CNT_Q_W'(FIFO_DEPTH));

	assign res_out.valid    = (count_q != '0);
	assign res_out.out_row  = show_res ? head.res_row : head.flush_row;
	assign res_out.out_last = !show_res;

	assign take = res_out.valid && res_out.ready;
	// entry is done unless a flush row still follows the smoothed one
	assign pop  = take && !(show_res && head.flush_ok);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				phase_q  <= 1'b0;
			end else if (take) begin
				phase_q <= 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[bench/binary_grid_threshold_smoother_unit_tb.sv]
// testbench for the binary grid threshold smoother: directed and random frames
`timescale 1ns / 1ps
module binary_grid_threshold_smoother_unit_tb;
	import bgts_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 600;
	localparam int PHASE_ROWS     = 40;

	typedef struct packed {
		logic [ROW_W-1:0] cells;
		logic             final_row;
	} grid_row_t;

	logic clk;
	logic arst_n;

	bgts_cfg_if cfg();
	bgts_row_if row_in();
	bgts_res_if row_out();

	binary_grid_threshold_smoother_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.row_in  (row_in),
		.row_out (row_out)
	);

	// predictor copy of the block state and registers
	logic [WIDTH_W-1:0] width_q;
	logic [THR_W-1:0]   thr_q;
	logic [ROW_W-1:0]   mid_q;
	logic [ROW_W-1:0]   up_q;
	int                 seen_q;

	grid_row_t pending_rows[$];

	int  mismatches;
	int  rows_sent;
	int  rows_checked;
	int  frames_sent;
	int  settings_used;
	int  idle_cycles;
	bit  src_quiet;
	bit  snk_quiet;

	always #4 clk = ~clk;

	function automatic int eff_width();
		return (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
	endfunction

	function automatic logic [ROW_W-1:0] width_mask(input int w);
		if (w >= ROW_W)
			return '1;
		return (64'd1 << w) - 64'd1;
	endfunction

	function automatic logic [ROW_W-1:0] smooth_cells(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] dn);
		logic [ROW_W-1:0] res;
		int w;
		int cnt;
		int i;
		int k;
		w = eff_width();
		res = mid & width_mask(w);
		if (w >= 3) begin
			for (i = 1; i < w - 1; i++) begin
				cnt = 0;
				for (k = i - 1; k <= i + 1; k++)
					cnt += int'(up[k]) + int'(mid[k]) + int'(dn[k]);
				res[i] = (cnt >= int'(thr_q));
			end
		end
		return res;
	endfunction

	task automatic predict_smoothed_rows(input logic [ROW_W-1:0] r, input logic l);
		logic [ROW_W-1:0] m;
		grid_row_t e;
		m = width_mask(eff_width());
		if (seen_q == 0) begin
			if (l) begin
				e.cells = r & m;
				e.final_row = 1'b1;
				pending_rows.push_back(e);
			end else begin
				mid_q = r;
				seen_q = 1;
			end
		end else begin
			e.cells = (seen_q == 1) ? (mid_q & m) : smooth_cells(up_q, mid_q, r);
			e.final_row = 1'b0;
			pending_rows.push_back(e);
			if (l) begin
				e.cells = r & m;
				e.final_row = 1'b1;
				pending_rows.push_back(e);
				mid_q = '0;
				up_q = '0;
				seen_q = 0;
			end else begin
				up_q = mid_q;
				mid_q = r;
				seen_q = 2;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
			input logic [ROW_W-1:0] want);
		mismatches++;
		$display("%0t: %s got %h expected %h", $time, what, got, want);
	endtask

	// monitor: register writes, accepted rows, then result rows
	always @(posedge clk) begin
		grid_row_t e;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.idx == REG_ROW_WIDTH)
					width_q = cfg.data[WIDTH_W-1:0];
				else if (cfg.idx == REG_WALL_THRESHOLD)
					thr_q = cfg.data[THR_W-1:0];
			end
			if (row_in.valid && row_in.ready) begin
				rows_sent++;
				predict_smoothed_rows(row_in.in_row, row_in.last_row);
			end
			if (row_out.valid && row_out.ready) begin
				rows_checked++;
				if (pending_rows.size() == 0) begin
					report_mismatch("unexpected result row", row_out.out_row, '0);
				end else begin
					e = pending_rows.pop_front();
					if (row_out.out_row !== e.cells)
						report_mismatch("out_row", row_out.out_row, e.cells);
					if (row_out.out_last !== e.final_row)
						report_mismatch("out_last", 64'(row_out.out_last), 64'(e.final_row));
				end
			end
		end
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (cfg.valid && cfg.ready) || (row_in.valid && row_in.ready)
				|| (row_out.valid && row_out.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side: random stall before each result
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = snk_quiet ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				row_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			row_out.ready <= 1'b1;
			do @(posedge clk); while (!(row_out.valid && row_out.ready));
		end
	end

	function automatic logic [ROW_W-1:0] rand_row();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: return a & b;
			1: return a | b;
			2: return a & b & {$urandom, $urandom};
			3: return a | b | {$urandom, $urandom};
			default: return a;
		endcase
	endfunction

	task automatic send_row(input logic [ROW_W-1:0] r, input logic l);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			row_in.valid <= 1'b0;
			row_in.in_row <= {$urandom, $urandom};
			row_in.last_row <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		row_in.valid <= 1'b1;
		row_in.in_row <= r;
		row_in.last_row <= l;
		do @(posedge clk); while (!row_in.ready);
	endtask

	task automatic send_frame(input int rows);
		int i;
		for (i = 0; i < rows; i++)
			send_row(rand_row(), i == rows - 1);
		frames_sent++;
	endtask

	task automatic wait_idle();
		row_in.valid <= 1'b0;
		// let the monitor take in the request accepted at the last edge
		@(posedge clk);
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] t);
		write_reg(REG_ROW_WIDTH, w);
		write_reg(REG_WALL_THRESHOLD, t);
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	// frames of one to four rows at the reset register values
	task automatic test_short_frames();
		send_row('1, 1'b1);
		send_row({32{2'b10}}, 1'b0);
		send_row({32{2'b01}}, 1'b1);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		send_row('0, 1'b0);
		send_row({32{2'b10}}, 1'b0);
		send_row('1, 1'b0);
		send_row(rand_row(), 1'b1);
		frames_sent += 4;
		wait_idle();
	endtask

	// threshold zero makes all interior wall, above nine all floor
	task automatic test_threshold_extremes();
		set_config(7'd64, 7'd0);
		send_row('0, 1'b0);
		send_row('0, 1'b0);
		send_row('0, 1'b1);
		wait_idle();
		set_config(7'd64, 7'd15);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		frames_sent += 2;
		wait_idle();
	endtask

	// widths below three leave no interior columns
	task automatic test_narrow_widths();
		set_config(7'd2, 7'd9);
		send_row('1, 1'b0);
		send_row('0, 1'b0);
		send_row('1, 1'b1);
		wait_idle();
		set_config(7'd0, 7'd1);
		send_row('1, 1'b1);
		frames_sent += 2;
		wait_idle();
	endtask

	task automatic test_random_frames();
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] t;
		int ph;
		int start;
		for (ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin w = 7'd3; t = 7'd5; end
				1: begin w = 7'd64; t = 7'd4; end
				2: begin w = 7'd64; t = 7'd9; end
				3: begin w = 7'd0; t = 7'd3; end
				4: begin w = 7'd1; t = 7'd2; end
				5: begin w = 7'd2; t = 7'd0; end
				6: begin w = 7'd127; t = 7'd6; end
				// upper data bits are dropped by the threshold register
				7: begin w = 7'd65; t = 7'h7a; end
				default: begin
					w = CFG_DATA_W'($urandom_range(3, 64));
					t = CFG_DATA_W'($urandom_range(0, 10));
				end
			endcase
			set_config(w, t);
			start = rows_sent;
			while (rows_sent - start < PHASE_ROWS) begin
				src_quiet = ($urandom_range(0, 3) == 0);
				snk_quiet = ($urandom_range(0, 3) == 0);
				send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(7, 24)
					: $urandom_range(1, 6));
			end
			wait_idle();
		end
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg.valid <= 1'b0;
		cfg.idx <= REG_ROW_WIDTH;
		cfg.data <= '0;
		row_in.valid <= 1'b0;
		row_in.in_row <= '0;
		row_in.last_row <= 1'b0;
		row_out.ready <= 1'b0;
		width_q = ROW_WIDTH_RESET;
		thr_q = WALL_THRESHOLD_RESET;
		mid_q = '0;
		up_q = '0;
		seen_q = 0;
		mismatches = 0;
		rows_sent = 0;
		rows_checked = 0;
		frames_sent = 0;
		settings_used = 1;
		idle_cycles = 0;
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_threshold_extremes();
		test_narrow_widths();
		test_random_frames();
		wait_idle();

		$display("sent %0d rows in %0d frames across %0d register settings",
			rows_sent, frames_sent, settings_used);
		$display("checked %0d result rows, %0d field mismatches", rows_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
